// ===== rtl/pnf_pkg.sv =====
package pnf_pkg;

  localparam int FRAME_BYTES_DEF   = 64;
  localparam int PREAMBLE_BITS_DEF = 32;
  localparam int STORE_DEPTH       = 64;
  localparam int STORE_AW          = $clog2(STORE_DEPTH);
  localparam int SYNC_BITS         = 16;
  localparam logic [SYNC_BITS-1:0] SYNC_RESET = 16'h4737;

  typedef enum logic [1:0] {
    PH_LOADING,
    PH_SENDING,
    PH_ENDED
  } phase_t;

  typedef enum logic [1:0] {
    ST_SENT     = 2'd0,
    ST_STORED   = 2'd1,
    ST_REJECTED = 2'd2,
    ST_END      = 2'd3
  } status_t;

  // Where the level of a tick comes from.
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_FIXED,
    SRC_BYTE
  } level_src_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] payload_byte;
  } cmd_t;

  typedef struct packed {
    logic    level;
    status_t status;
  } res_t;

  // Decoded request, carried from the control stage to the output stage.
  typedef struct packed {
    status_t    status;
    level_src_t src;
    logic       fixed_bit;
    logic [2:0] bit_sel;
  } req_info_t;

endpackage

// ===== rtl/pnf_store.sv =====
module pnf_store
  import pnf_pkg::*;
(
  input  logic                clk,
  input  logic                we,
  input  logic [STORE_AW-1:0] waddr,
  input  logic [7:0]          wdata,
  input  logic                re,
  input  logic [STORE_AW-1:0] raddr,
  output logic [7:0]          rdata
);

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pnf_ctrl.sv =====
module pnf_ctrl
  import pnf_pkg::*;
#(
  parameter int FRAME_BYTES   = FRAME_BYTES_DEF,
  parameter int PREAMBLE_BITS = PREAMBLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  cmd_t                cmd,
  input  logic                sync_we,
  input  logic [15:0]         sync_wdata,
  output req_info_t           info,
  output logic                store_we,
  output logic [STORE_AW-1:0] store_waddr,
  output logic [7:0]          store_wdata,
  output logic                store_re,
  output logic [STORE_AW-1:0] store_raddr
);

  localparam int CAP   = (FRAME_BYTES < STORE_DEPTH) ? FRAME_BYTES : STORE_DEPTH;
  localparam int CW    = $clog2(CAP + 1);
  localparam int TOTAL = PREAMBLE_BITS + SYNC_BITS + 8 * FRAME_BYTES + 1;
  localparam int SW    = $clog2(TOTAL + 1);

  localparam logic [SW-1:0] S_PRE   = SW'(PREAMBLE_BITS);
  localparam logic [SW-1:0] S_SYNC  = SW'(SYNC_BITS);
  localparam logic [SW-1:0] S_DATA  = SW'(8 * FRAME_BYTES);
  localparam logic [SW-1:0] S_TOTAL = SW'(TOTAL);
  localparam logic [CW-1:0] C_CAP   = CW'(CAP);
  localparam logic [3:0]    SYNC_MSB = 4'(SYNC_BITS - 1);

  phase_t         phase, phase_next;
  logic [CW-1:0]  loaded_count, loaded_count_next;
  logic [SW-1:0]  symbol_index, symbol_index_next;
  logic [15:0]    sync_word;

  logic [CW-1:0]  lc_eff;
  logic [SW-1:0]  s_eff, d_sync, d_data, byte_idx;
  logic           can_store, can_send;

  // Shared decode of the current request.
  always_comb begin
    lc_eff    = (phase == PH_ENDED) ? '0 : loaded_count;
    s_eff     = (phase == PH_LOADING) ? '0 : symbol_index;
    can_store = (phase != PH_SENDING) && (lc_eff < C_CAP);
    can_send  = (phase != PH_ENDED) && (s_eff < S_TOTAL);
    d_sync    = s_eff - S_PRE;
    d_data    = d_sync - S_SYNC;
    byte_idx  = d_data >> 3;
  end

  // Next state.
  always_comb begin
    phase_next        = phase;
    loaded_count_next = loaded_count;
    symbol_index_next = symbol_index;
    if (accept) begin
      if (!cmd.mode) begin
        if (phase != PH_SENDING) begin
          phase_next        = PH_LOADING;
          loaded_count_next = can_store ? lc_eff + 1'b1 : lc_eff;
        end
      end else if (can_send) begin
        phase_next        = PH_SENDING;
        symbol_index_next = s_eff + 1'b1;
      end else begin
        phase_next = PH_ENDED;
      end
    end
  end

  // Outputs.
  always_comb begin
    info        = '{status: ST_SENT, src: SRC_ZERO, fixed_bit: 1'b0, bit_sel: d_data[2:0]};
    store_we    = 1'b0;
    store_waddr = STORE_AW'(lc_eff);
    store_wdata = cmd.payload_byte;
    store_re    = 1'b0;
    store_raddr = STORE_AW'(byte_idx);
    if (!cmd.mode) begin
      info.status = can_store ? ST_STORED : ST_REJECTED;
      store_we    = accept && can_store;
    end else if (!can_send) begin
      info.status = ST_END;
    end else if (s_eff < S_PRE) begin
      info.src       = SRC_FIXED;
      info.fixed_bit = s_eff[0];
    end else if (d_sync < S_SYNC) begin
      info.src       = SRC_FIXED;
      info.fixed_bit = sync_word[SYNC_MSB - d_sync[3:0]];
    end else if ((d_data < S_DATA) && (byte_idx < SW'(loaded_count))) begin
      info.src = SRC_BYTE;
      store_re = accept;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LOADING;
      loaded_count <= '0;
      symbol_index <= '0;
      sync_word    <= SYNC_RESET;
    end else begin
      phase        <= phase_next;
      loaded_count <= loaded_count_next;
      symbol_index <= symbol_index_next;
      if (sync_we) begin
        sync_word <= sync_wdata;
      end
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= C_CAP)
    else $error("loaded_count above capacity");

  a_no_write_sending: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SENDING) |-> !store_we)
    else $error("store written while sending");

  a_read_loaded: assert property (@(posedge clk) disable iff (rst)
    store_re |-> (byte_idx < SW'(loaded_count)) && (phase != PH_ENDED))
    else $error("store read beyond loaded bytes");

endmodule

// ===== rtl/preamble_sync_nrz_framer.sv =====
// Transmit framer for a 2-FSK NRZ link.
// Request channel (cmd_valid / cmd_stall / cmd): mode 0 appends
// payload_byte to the frame store, mode 1 is a symbol tick that asks for
// the next NRZ level. A frame is the preamble (alternating, starting with
// 0), the sync word MSB first, FRAME_BYTES bytes MSB first (bytes not
// loaded go out as zero) and one idle 0; later ticks report end.
// Result channel (res_valid / res_stall / res): one result per request,
// level plus status (sent, stored, rejected, ended), in request order.
// sync_we / sync_wdata load the sync word; write it only while idle.
// A taken request is registered in the decode stage (with the store read),
// then in the output register. Throughput is one request per cycle unless
// results stall; only ticks on loaded payload bytes read the store.
// A stalled result holds; the decode stage keeps taking requests until
// it is full too, then cmd_stall rises.
// Reset: frame empty, loading phase, sync word 0x4737. The store itself
// is not cleared; only loaded entries are ever read.
module preamble_sync_nrz_framer
  import pnf_pkg::*;
#(
  parameter int FRAME_BYTES   = FRAME_BYTES_DEF,
  parameter int PREAMBLE_BITS = PREAMBLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_t        cmd,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res,
  input  logic        sync_we,
  input  logic [15:0] sync_wdata
);

  logic                accept;
  req_info_t           info;
  logic                store_we, store_re;
  logic [STORE_AW-1:0] store_waddr, store_raddr;
  logic [7:0]          store_wdata, store_rdata;

  // decode stage
  logic      a_valid;
  req_info_t a_info;
  logic      advance;
  logic      level_next;

  assign advance   = a_valid && (!res_valid || !res_stall);
  assign cmd_stall = a_valid && !advance;
  assign accept    = cmd_valid && !cmd_stall;

  pnf_ctrl #(
    .FRAME_BYTES  (FRAME_BYTES),
    .PREAMBLE_BITS(PREAMBLE_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd        (cmd),
    .sync_we    (sync_we),
    .sync_wdata (sync_wdata),
    .info       (info),
    .store_we   (store_we),
    .store_waddr(store_waddr),
    .store_wdata(store_wdata),
    .store_re   (store_re),
    .store_raddr(store_raddr)
  );

  pnf_store u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(store_waddr),
    .wdata(store_wdata),
    .re   (store_re),
    .raddr(store_raddr),
    .rdata(store_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_info <= info;
    end
  end

  // Pick the level; payload bits go MSB first.
  always_comb begin
    case (a_info.src)
      SRC_FIXED: level_next = a_info.fixed_bit;
      SRC_BYTE:  level_next = store_rdata[~a_info.bit_sel];
      default:   level_next = 1'b0;
    endcase
  end

  // Output register: loads whenever it is empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      res_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.level  <= level_next;
      res.status <= a_info.status;
    end
  end

  a_hold_decode: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !advance) |=> a_valid && $stable(a_info))
    else $error("decode stage lost a request");

  a_level_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.status != ST_SENT)) |-> !res.level)
    else $error("nonzero level on non-symbol result");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> a_valid && res_valid && res_stall)
    else $error("request stalled with room in the pipeline");

endmodule

// ===== test/testbench.sv =====
// Checks the NRZ framer request by request against a cycle-free model of the frame.
module testbench;
  import pnf_pkg::*;

  // Request modes
  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // Frame geometry at the block's default parameters
  localparam int PRE_BITS      = PREAMBLE_BITS_DEF;
  localparam int PAYLOAD_BITS  = 8 * FRAME_BYTES_DEF;
  localparam int FRAME_SYMBOLS = PRE_BITS + SYNC_BITS + PAYLOAD_BITS + 1;
  localparam int CAPACITY      = (FRAME_BYTES_DEF < STORE_DEPTH) ? FRAME_BYTES_DEF : STORE_DEPTH;

  // Symbols per frame left after the first 40, i.e. after 8 sync bits
  localparam int SPLIT_TICKS = PRE_BITS + 8;
  localparam int REST_TICKS  = FRAME_SYMBOLS - SPLIT_TICKS;

  localparam int IDLE_PCT      = 32;
  localparam int NOISE_PCT     = 6;
  localparam int CALM_FROM     = 700;   // no idling on either side in [CALM_FROM, CALM_TO)
  localparam int CALM_TO       = 900;
  localparam int HOLD_AT       = 250;   // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES   = 150;
  localparam int QUIET_LIMIT   = 3000;  // cycles without any handshake before giving up
  localparam int DRAIN_CYCLES  = 6;     // settling margin after the last result

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  cmd_t        cmd = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_t        res;
  logic        sync_we = 1'b0;
  logic [15:0] sync_wdata = '0;

  preamble_sync_nrz_framer u_top (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .sync_we    (sync_we),
    .sync_wdata (sync_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Framer model state (reset values)
  // ---------------------------------------------------------------------------
  logic [7:0]  frame_mem [STORE_DEPTH];
  int          bytes_loaded  = 0;
  int          next_symbol   = 0;
  phase_t      tx_phase      = PH_LOADING;
  logic [15:0] sync_word_cur = SYNC_RESET;

  cmd_t cmds_to_send [$];   // requests not yet offered
  res_t results_due  [$];   // expected results, oldest first

  int errors       = 0;
  int cmds_taken   = 0;
  int results_seen = 0;

  // Advance the frame model by one request and return the level/status it yields.
  function automatic res_t framer_next_result(cmd_t c);
    res_t        r;
    int          s;
    int          bi;
    logic [7:0]  v;
    r.level  = 1'b0;
    r.status = ST_SENT;
    if (c.mode == MODE_APPEND) begin
      if (tx_phase == PH_SENDING) begin
        r.status = ST_REJECTED;
      end else begin
        // first append after the end opens a new, empty frame
        if (tx_phase == PH_ENDED) begin
          bytes_loaded = 0;
          tx_phase     = PH_LOADING;
        end
        if (bytes_loaded >= CAPACITY) begin
          r.status = ST_REJECTED;
        end else begin
          frame_mem[bytes_loaded] = c.payload_byte;
          bytes_loaded++;
          r.status = ST_STORED;
        end
      end
    end else begin
      if (tx_phase == PH_LOADING) begin
        tx_phase    = PH_SENDING;
        next_symbol = 0;
      end
      if (tx_phase == PH_SENDING && next_symbol < FRAME_SYMBOLS) begin
        s = next_symbol;
        if (s < PRE_BITS) begin
          r.level = s[0];                                    // 0101... preamble
        end else if (s < PRE_BITS + SYNC_BITS) begin
          r.level = sync_word_cur[SYNC_BITS - 1 - (s - PRE_BITS)];
        end else if (s < PRE_BITS + SYNC_BITS + PAYLOAD_BITS) begin
          bi = s - PRE_BITS - SYNC_BITS;
          // bytes never loaded go out as zero
          v = (bi / 8 < bytes_loaded && bi / 8 < STORE_DEPTH) ? frame_mem[bi / 8] : 8'h00;
          r.level = v[7 - bi % 8];
        end else begin
          r.level = 1'b0;                                    // trailing idle bit
        end
        next_symbol++;
        r.status = ST_SENT;
      end else begin
        tx_phase = PH_ENDED;
        r.status = ST_END;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: offers queued requests, idles at random, holds while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        results_due.push_back(framer_next_result(cmd));
        cmds_taken++;
      end
      // a stalled request stays put; otherwise pick the next one or idle
      if (!cmd_valid || !cmd_stall) begin
        if (cmds_to_send.size() != 0 &&
            ((cmds_taken >= CALM_FROM && cmds_taken < CALM_TO) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          cmd       <= cmds_to_send.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compares each result, drives res_stall
  // ---------------------------------------------------------------------------
  res_t want;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (results_due.size() == 0) begin
        $error("result with nothing expected: level %0d status %0d", res.level, res.status);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (res.level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, res.level);
          errors++;
        end
        if (res.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res.status);
          errors++;
        end
      end
    end
    // one long hold-off so the pipeline fills and backs up into cmd_stall
    if (!hold_done && results_seen >= HOLD_AT) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (results_seen >= CALM_FROM && results_seen < CALM_TO) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any handshake
  // ---------------------------------------------------------------------------
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("[preamble_sync_nrz_framer] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_cmd(logic m, logic [7:0] b);
    cmd_t c;
    c.mode         = m;
    c.payload_byte = b;
    cmds_to_send.push_back(c);
  endtask

  task automatic queue_loads(int n);
    for (int i = 0; i < n; i++) push_cmd(MODE_APPEND, 8'($urandom));
  endtask

  // n ticks, with the odd stray append mixed in (rejected while sending)
  task automatic queue_ticks(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < NOISE_PCT) push_cmd(MODE_APPEND, 8'($urandom));
      push_cmd(MODE_TICK, 8'($urandom));
    end
  endtask

  // wait until every request is taken and answered, then let the pipe settle
  task automatic drain();
    while (cmds_to_send.size() != 0 || cmd_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sync word write; only called with nothing in flight
  task automatic write_sync(logic [15:0] v);
    sync_we       <= 1'b1;
    sync_wdata    <= v;
    sync_word_cur  = v;
    @(posedge clk);
    sync_we <= 1'b0;
  endtask

  initial begin
    int n_loaded;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: tick straight after reset starts an empty-payload frame with
    // the reset sync word; appends while sending are refused.
    push_cmd(MODE_TICK, 8'h00);
    push_cmd(MODE_APPEND, 8'h00);
    push_cmd(MODE_APPEND, 8'hFF);
    for (int i = 1; i < SPLIT_TICKS; i++) push_cmd(MODE_TICK, 8'hFF);
    drain();

    // Sync word changed halfway through the sync field: the remaining sync
    // bits come from the new value.
    write_sync(16'hFFFF);
    @(negedge clk);
    queue_ticks(REST_TICKS);
    repeat ($urandom_range(1, 3)) push_cmd(MODE_TICK, 8'h00);
    drain();

    // Second frame: append after the end restarts loading; overfill by two to
    // hit the capacity limit, extremes of the byte first.
    write_sync(16'h0000);
    @(negedge clk);
    push_cmd(MODE_APPEND, 8'h00);
    push_cmd(MODE_APPEND, 8'hFF);
    queue_loads(CAPACITY);
    queue_ticks(SPLIT_TICKS);
    drain();

    write_sync(16'($urandom));
    @(negedge clk);
    queue_ticks(REST_TICKS);
    repeat ($urandom_range(1, 3)) push_cmd(MODE_TICK, 8'h00);
    drain();

    // Third frame with a short random load: unloaded bytes go out as zero.
    // Sent only through the first unloaded byte; the frame stays open.
    write_sync(16'($urandom));
    @(negedge clk);
    n_loaded = $urandom_range(1, 8);
    queue_loads(n_loaded);
    queue_ticks(PRE_BITS + SYNC_BITS + 8 * (n_loaded + 1));
    drain();

    // Noise: random modes, broken frames.
    write_sync(16'($urandom));
    @(negedge clk);
    for (int i = 0; i < 80; i++) push_cmd(1'($urandom), 8'($urandom));
    drain();

    if (results_due.size() != 0) begin
      $error("%0d results never arrived", results_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[preamble_sync_nrz_framer] OK");
    end else begin
      $display("[preamble_sync_nrz_framer] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pnf_pkg.sv
rtl/pnf_store.sv
rtl/pnf_ctrl.sv
rtl/preamble_sync_nrz_framer.sv
test/testbench.sv
